// File: hw/rtl/atrs_pkg.sv
package atrs_pkg;

    // Price and result formats
    localparam int PRICE_BITS = 32;
    localparam int FRAC_W     = 8;
    localparam int AVG_W      = 40;

    // Window configuration
    localparam int          MAX_WINDOW_DEF = 256;
    localparam int          CFG_W          = 9;
    localparam logic [8:0]  WINDOW_RESET   = 9'd14;

    // Configuration port
    localparam int          PADDR_W           = 3;
    localparam int          PDATA_W           = 32;
    localparam logic [0:0]  REG_WINDOW_LENGTH = 1'b0;

    // Derived defaults for the divider
    localparam int WIN_W_DEF = $clog2(MAX_WINDOW_DEF + 1);
    localparam int SUM_W_DEF = PRICE_BITS + $clog2(MAX_WINDOW_DEF);
    localparam int QUO_W_DEF = SUM_W_DEF + FRAC_W;

    typedef struct packed {
        logic [PRICE_BITS-1:0] bar_high;
        logic [PRICE_BITS-1:0] bar_low;
        logic [PRICE_BITS-1:0] bar_close;
    } t_bar_in;

    typedef struct packed {
        logic [PRICE_BITS-1:0] range_ticks;
        logic [AVG_W-1:0]      average_range;
        logic                  average_valid;
    } t_bar_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAX,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/atrs_div.sv
module atrs_div #(
    parameter int DVD_W = atrs_pkg::QUO_W_DEF,
    parameter int DVS_W = atrs_pkg::WIN_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/average_true_range_sma_core.sv
// Steps: IDLE, DIFF, MAX, SUM, DIV, DONE. A bar with a full window waits in DIV on the
//   bit-serial divider of sum*256 by the window; while the window fills, DIV is skipped.
// The first bar after reset or a window write goes from DIFF to DONE and only records its
//   close. One bar is taken at a time; the next is taken while a result waits in the output register.
// Reset: window length 14, empty window, no previous close. The ring memory is not
//   cleared; the fill count keeps unwritten entries from being read.
module average_true_range_sma_core #(
    parameter int MAX_WINDOW = atrs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  atrs_pkg::t_bar_in                   i_in_data,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output atrs_pkg::t_bar_out                  o_out_data,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [atrs_pkg::PADDR_W-1:0]        paddr,
    input  logic [atrs_pkg::PDATA_W-1:0]        pwdata,
    output logic [atrs_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int PW    = atrs_pkg::PRICE_BITS;
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = PW + $clog2(MAX_WINDOW);
    localparam int QUO_W = SUM_W + atrs_pkg::FRAC_W;
    localparam int AVG_W = atrs_pkg::AVG_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    atrs_pkg::t_state             r_state, n_state;

    logic [atrs_pkg::CFG_W-1:0]   r_window_length;
    logic [PW-1:0]                r_prev_close;
    logic                         r_have_prev;
    logic [IDX_W-1:0]             r_wr_idx;
    logic [WIN_W-1:0]             r_fill;
    logic [SUM_W-1:0]             r_sum;

    atrs_pkg::t_bar_in            r_bar;
    logic [PW-1:0]                r_d_hl, r_d_hc, r_d_lc;
    logic [PW-1:0]                r_tr;
    logic [AVG_W-1:0]             r_res_avg;
    logic                         r_res_valid;

    logic                         r_out_valid;
    atrs_pkg::t_bar_out           r_out;

    // True-range ring: one write and one registered read port
    logic [PW-1:0]                r_ring [MAX_WINDOW];
    logic [PW-1:0]                r_ring_q;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]   w_eff;
    logic               cfg_wr;
    logic               cfg_win_wr;
    logic               slot_free;
    logic               win_full;
    logic [WIN_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   n_wr_idx;
    logic [WIN_W-1:0]   n_fill;
    logic [SUM_W-1:0]   n_sum;
    logic [PW-1:0]      tr_max;
    logic [AVG_W-1:0]   avg_sat;

    // FSM strobes
    logic s_take, s_first, s_diff, s_max, s_sum, s_div_start, s_div_end, s_load;

    logic               div_busy;
    logic               div_done;
    logic [QUO_W-1:0]   div_q;

    function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Clamp the programmed window: zero means one, anything past the ring depth
    // means the full ring
    always_comb begin
        if (r_window_length == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = WIN_W'(r_window_length);
        end
    end

    assign cfg_wr     = psel & penable & pwrite & pready;
    assign cfg_win_wr = cfg_wr && (paddr[2] == atrs_pkg::REG_WINDOW_LENGTH);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == atrs_pkg::REG_WINDOW_LENGTH) ?
                        atrs_pkg::PDATA_W'(r_window_length) : '0;

    // The output register is free when empty or being drained this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    // Ring bookkeeping for the bar in the update cycle
    always_comb begin
        win_full = (r_fill >= w_eff);
        idx_inc  = WIN_W'(r_wr_idx) + WIN_W'(1);
        n_wr_idx = (idx_inc >= w_eff) ? '0 : idx_inc[IDX_W-1:0];
        n_fill   = win_full ? r_fill : (r_fill + WIN_W'(1));
        // Drop the oldest range once the window is full, then add the new one
        n_sum    = r_sum - (win_full ? SUM_W'(r_ring_q) : '0) + SUM_W'(r_tr);
    end

    always_comb begin
        tr_max = r_d_hl;
        if (r_d_hc > tr_max) begin
            tr_max = r_d_hc;
        end
        if (r_d_lc > tr_max) begin
            tr_max = r_d_lc;
        end
    end

    // Clip the quotient to the 40-bit result
    assign avg_sat = (|div_q[QUO_W-1:AVG_W]) ? '1 : div_q[AVG_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        s_take      = 1'b0;
        s_first     = 1'b0;
        s_diff      = 1'b0;
        s_max       = 1'b0;
        s_sum       = 1'b0;
        s_div_start = 1'b0;
        s_div_end   = 1'b0;
        s_load      = 1'b0;
        case (r_state)
            atrs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    s_take  = 1'b1;
                    n_state = atrs_pkg::ST_DIFF;
                end
            end
            atrs_pkg::ST_DIFF: begin
                // First bar only records its close
                if (!r_have_prev) begin
                    s_first = 1'b1;
                    n_state = atrs_pkg::ST_DONE;
                end else begin
                    s_diff  = 1'b1;
                    n_state = atrs_pkg::ST_MAX;
                end
            end
            atrs_pkg::ST_MAX: begin
                s_max   = 1'b1;
                n_state = atrs_pkg::ST_SUM;
            end
            atrs_pkg::ST_SUM: begin
                s_sum = 1'b1;
                if (n_fill >= w_eff) begin
                    s_div_start = 1'b1;
                    n_state     = atrs_pkg::ST_DIV;
                end else begin
                    n_state = atrs_pkg::ST_DONE;
                end
            end
            atrs_pkg::ST_DIV: begin
                if (div_done) begin
                    s_div_end = 1'b1;
                    n_state   = atrs_pkg::ST_DONE;
                end
            end
            atrs_pkg::ST_DONE: begin
                // Hold the result until the output register can take it
                if (slot_free) begin
                    s_load  = 1'b1;
                    n_state = atrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atrs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != atrs_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Window state; a window write clears it and wins over any update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= atrs_pkg::WINDOW_RESET;
            r_prev_close    <= '0;
            r_have_prev     <= 1'b0;
            r_wr_idx        <= '0;
            r_fill          <= '0;
            r_sum           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (s_first) begin
                r_prev_close <= r_bar.bar_close;
                r_have_prev  <= 1'b1;
            end
            if (s_sum) begin
                r_prev_close <= r_bar.bar_close;
                r_wr_idx     <= n_wr_idx;
                r_fill       <= n_fill;
                r_sum        <= n_sum;
            end
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_win_wr) begin
                r_window_length <= pwdata[atrs_pkg::CFG_W-1:0];
                r_prev_close    <= '0;
                r_have_prev     <= 1'b0;
                r_wr_idx        <= '0;
                r_fill          <= '0;
                r_sum           <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item payload through the steps
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_bar <= i_in_data;
        end
        if (s_first) begin
            r_tr        <= '0;
            r_res_avg   <= '0;
            r_res_valid <= 1'b0;
        end
        if (s_diff) begin
            r_d_hl <= abs_diff(r_bar.bar_high, r_bar.bar_low);
            r_d_hc <= abs_diff(r_bar.bar_high, r_prev_close);
            r_d_lc <= abs_diff(r_bar.bar_low, r_prev_close);
        end
        if (s_max) begin
            r_tr <= tr_max;
        end
        if (s_sum && !s_div_start) begin
            r_res_avg   <= '0;
            r_res_valid <= 1'b0;
        end
        if (s_div_end) begin
            r_res_avg   <= avg_sat;
            r_res_valid <= 1'b1;
        end
        if (s_load) begin
            r_out.range_ticks   <= r_tr;
            r_out.average_range <= r_res_avg;
            r_out.average_valid <= r_res_valid;
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: read the entry to be replaced in DIFF, write the new range in SUM
    // at the same slot; one item at a time keeps them apart
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_diff) begin
            r_ring_q <= r_ring[r_wr_idx];
        end
        if (s_sum) begin
            r_ring[r_wr_idx] <= r_tr;
        end
    end

    // ------------------------------------------------------------------
    // Divide sum * 256 by the window, one quotient bit a cycle
    // ------------------------------------------------------------------
    atrs_div #(
        .DVD_W (QUO_W),
        .DVS_W (WIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend ({n_sum, atrs_pkg::FRAC_W'(0)}),
        .i_divisor  (w_eff),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wr_idx) < 32'(w_eff))
        else $error("ring write index outside the window");

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(w_eff))
        else $error("fill count beyond the window");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atrs_pkg::ST_DIV) |-> (div_busy || div_done))
        else $error("waiting on a divider that is not running");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == atrs_pkg::ST_DONE))
        else $error("result loaded outside the done step");

endmodule
